FILE: src/free_block_cache_fifo_evict_unit_defines.svh
// Assertion macros used by the free block cache datapath.
`ifndef FREE_BLOCK_CACHE_FIFO_EVICT_UNIT_DEFINES_SVH
`define FREE_BLOCK_CACHE_FIFO_EVICT_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define FBC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FBC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/fbc_pkg.sv
// Shared types and constants of the free block cache.
package fbc_pkg;

  localparam int unsigned DepthDefault    = 16;
  localparam int unsigned AddrBitsDefault = 48;
  localparam int unsigned SizeBitsDefault = 40;
  localparam int unsigned AlignBits       = 17;
  localparam int unsigned CfgCountBits    = 5;
  localparam int unsigned CfgBytesBits    = 40;
  localparam int unsigned CfgIdxBits      = 2;
  localparam int unsigned CodeBits        = 2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ACT_HIT     = 2'd0,
    ACT_FORWARD = 2'd1,
    ACT_RELEASE = 2'd2
  } act_e;

  // Where a pushed result takes its fields from.
  typedef enum logic [1:0] {
    SRC_PEND = 2'd0,
    SRC_SCAN = 2'd1,
    SRC_REQ  = 2'd2,
    SRC_FWD  = 2'd3
  } src_e;

  localparam logic [CfgIdxBits-1:0] CFG_MAX_COUNT = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MAX_BYTES = 2'd1;

  typedef struct packed {
    logic latch;
    logic idx_clr;
    logic idx_inc;
    logic remove;
    logic rm_head;
    logic append;
    logic push;
    src_e src;
    act_e act;
    logic last;
    logic pend_load;
    logic pend_from_req;
  } cmd_t;

  typedef struct packed {
    logic oversized;
    logic null_addr;
    logic over;
    logic empty;
    logic scan_end;
    logic match;
    logic out_free;
  } stat_t;

endpackage

FILE: src/fbc_ctrl.sv
// Sequencer of the free block cache: scan, evict and flush control.
module fbc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  input  fbc_pkg::op_e        in_op_i,
  output logic                s_axis_tready,
  input  fbc_pkg::stat_t      stat_i,
  output fbc_pkg::cmd_t       cmd_o
);
  import fbc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ALLOC, ST_FREE, ST_EVICT, ST_FLUSH, ST_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   pend_v_q, pend_v_d;

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    cmd_o    = '0;
    state_d  = state_q;
    pend_v_d = pend_v_q;
    unique case (state_q)
      ST_IDLE: begin
        pend_v_d = 1'b0;
        if (s_axis_tvalid) begin
          cmd_o.latch   = 1'b1;
          cmd_o.idx_clr = 1'b1;
          unique case (in_op_i)
            OP_ALLOC: state_d = ST_ALLOC;
            OP_FREE:  state_d = ST_FREE;
            OP_FLUSH: state_d = ST_FLUSH;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ALLOC: begin
        if (stat_i.out_free) begin
          if (stat_i.scan_end) begin
            cmd_o.push = 1'b1;
            cmd_o.src  = SRC_FWD;
            cmd_o.act  = ACT_FORWARD;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else if (stat_i.match) begin
            cmd_o.push   = 1'b1;
            cmd_o.src    = SRC_SCAN;
            cmd_o.act    = ACT_HIT;
            cmd_o.last   = 1'b1;
            cmd_o.remove = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      ST_FREE: begin
        if (stat_i.oversized) begin
          if (stat_i.out_free) begin
            cmd_o.push = 1'b1;
            cmd_o.src  = SRC_REQ;
            cmd_o.act  = ACT_RELEASE;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end else if (stat_i.null_addr) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (stat_i.out_free) begin
          // A held result goes out only once it is known whether more follow.
          cmd_o.src = SRC_PEND;
          cmd_o.act = ACT_RELEASE;
          if (stat_i.over) begin
            cmd_o.push      = pend_v_q;
            cmd_o.pend_load = 1'b1;
            pend_v_d        = 1'b1;
            if (!stat_i.empty) begin
              cmd_o.remove  = 1'b1;
              cmd_o.rm_head = 1'b1;
            end else begin
              cmd_o.pend_from_req = 1'b1;
              state_d             = ST_DRAIN;
            end
          end else begin
            cmd_o.append = 1'b1;
            cmd_o.push   = pend_v_q;
            cmd_o.last   = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      ST_FLUSH: begin
        if (stat_i.out_free) begin
          cmd_o.src  = SRC_PEND;
          cmd_o.act  = ACT_RELEASE;
          cmd_o.push = pend_v_q;
          if (!stat_i.empty) begin
            cmd_o.pend_load = 1'b1;
            cmd_o.remove    = 1'b1;
            cmd_o.rm_head   = 1'b1;
            pend_v_d        = 1'b1;
          end else begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end
        end
      end
      ST_DRAIN: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.src  = SRC_PEND;
          cmd_o.act  = ACT_RELEASE;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      pend_v_q <= pend_v_d;
    end
  end

endmodule

FILE: src/fbc_datapath.sv
// Entry store, limit checks, result staging and output register of the cache.
`include "free_block_cache_fifo_evict_unit_defines.svh"

module fbc_datapath #(
  parameter int unsigned DEPTH     = fbc_pkg::DepthDefault,
  parameter int unsigned ADDR_BITS = fbc_pkg::AddrBitsDefault,
  parameter int unsigned SIZE_BITS = fbc_pkg::SizeBitsDefault,
  parameter int unsigned DATA_W    =
    ((ADDR_BITS + SIZE_BITS + fbc_pkg::AlignBits + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [DATA_W-1:0]                    s_axis_tdata,
  input  fbc_pkg::op_e                         in_op_i,
  input  logic                                 cfg_valid_i,
  input  logic [fbc_pkg::CfgIdxBits-1:0]       cfg_index_i,
  input  logic [fbc_pkg::CfgBytesBits-1:0]     cfg_data_i,
  input  fbc_pkg::cmd_t                        cmd_i,
  output fbc_pkg::stat_t                       stat_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [DATA_W-1:0]                    m_axis_tdata,
  output logic [fbc_pkg::CodeBits-1:0]         m_axis_tuser,
  output logic                                 m_axis_tlast
);
  import fbc_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned TOT_W  = SIZE_BITS + CNT_W;
  localparam int unsigned LIM_W  = ((CNT_W > CfgCountBits) ? CNT_W : CfgCountBits) + 1;
  localparam int unsigned SUM_W  = ((TOT_W > CfgBytesBits) ? TOT_W : CfgBytesBits) + 1;
  localparam int unsigned CMP_W  = (SIZE_BITS > CfgBytesBits) ? SIZE_BITS : CfgBytesBits;
  localparam int unsigned PAD_W  = DATA_W - ADDR_BITS - SIZE_BITS - AlignBits;

  logic [ADDR_BITS-1:0] e_addr_q  [DEPTH];
  logic [SIZE_BITS-1:0] e_bytes_q [DEPTH];
  logic [AlignBits-1:0] e_align_q [DEPTH];

  logic [ADDR_BITS-1:0] req_addr_q;
  logic [SIZE_BITS-1:0] req_bytes_q;
  logic [AlignBits-1:0] req_align_q;
  op_e                  req_op_q;

  logic [ADDR_BITS-1:0] pend_addr_q;
  logic [SIZE_BITS-1:0] pend_bytes_q;
  logic [AlignBits-1:0] pend_align_q;

  logic [CNT_W-1:0]        cnt_q, cnt_d, idx_q;
  logic [TOT_W-1:0]        tot_q, tot_d;
  logic [CfgCountBits-1:0] max_cnt_q;
  logic [CfgBytesBits-1:0] max_bytes_q;

  logic                 ov_q, last_q;
  act_e                 act_q;
  logic [ADDR_BITS-1:0] o_addr_q, o_addr_d;
  logic [SIZE_BITS-1:0] o_bytes_q, o_bytes_d;
  logic [AlignBits-1:0] o_align_q, o_align_d;

  logic [IDX_W-1:0] scan_ix, rm_ix;
  logic [LIM_W-1:0] lim, cnt_next;
  logic [SUM_W-1:0] sum;
  logic             room;

  assign scan_ix = idx_q[IDX_W-1:0];
  assign rm_ix   = cmd_i.rm_head ? '0 : scan_ix;
  assign room    = (cnt_q < CNT_W'(DEPTH));

  assign lim      = (LIM_W'(max_cnt_q) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(max_cnt_q);
  assign cnt_next = LIM_W'(cnt_q) + LIM_W'(1);
  assign sum      = SUM_W'(tot_q) + SUM_W'(req_bytes_q);

  assign stat_o.oversized = CMP_W'(req_bytes_q) > CMP_W'(max_bytes_q);
  assign stat_o.null_addr = (req_addr_q == '0);
  assign stat_o.over      = (cnt_next > lim) || (sum > SUM_W'(max_bytes_q));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.scan_end  = (idx_q == cnt_q) || (req_op_q != OP_ALLOC);
  assign stat_o.match     = (e_bytes_q[scan_ix] == req_bytes_q) &&
                            (e_align_q[scan_ix] == req_align_q);
  assign stat_o.out_free  = !ov_q || m_axis_tready;

  always_comb begin
    cnt_d = cnt_q;
    tot_d = tot_q;
    if (cmd_i.remove) begin
      cnt_d = cnt_q - CNT_W'(1);
      tot_d = tot_q - TOT_W'(e_bytes_q[rm_ix]);
    end else if (cmd_i.append && room) begin
      cnt_d = cnt_q + CNT_W'(1);
      tot_d = tot_q + TOT_W'(req_bytes_q);
    end
  end

  always_comb begin
    case (cmd_i.src)
      SRC_PEND: begin
        o_addr_d  = pend_addr_q;
        o_bytes_d = pend_bytes_q;
        o_align_d = pend_align_q;
      end
      SRC_SCAN: begin
        o_addr_d  = e_addr_q[scan_ix];
        o_bytes_d = e_bytes_q[scan_ix];
        o_align_d = e_align_q[scan_ix];
      end
      SRC_REQ: begin
        o_addr_d  = req_addr_q;
        o_bytes_d = req_bytes_q;
        o_align_d = req_align_q;
      end
      default: begin
        o_addr_d  = '0;
        o_bytes_d = req_bytes_q;
        o_align_d = req_align_q;
      end
    endcase
  end

  // Removal closes the gap by moving every later entry down one place.
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DEPTH - 1; j++) begin
      if (cmd_i.remove && (IDX_W'(j) >= rm_ix)) begin
        e_addr_q[j]  <= e_addr_q[j+1];
        e_bytes_q[j] <= e_bytes_q[j+1];
        e_align_q[j] <= e_align_q[j+1];
      end
    end
    if (cmd_i.append && !cmd_i.remove && room) begin
      e_addr_q[cnt_q[IDX_W-1:0]]  <= req_addr_q;
      e_bytes_q[cnt_q[IDX_W-1:0]] <= req_bytes_q;
      e_align_q[cnt_q[IDX_W-1:0]] <= req_align_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_addr_q  <= s_axis_tdata[ADDR_BITS-1:0];
      req_bytes_q <= s_axis_tdata[ADDR_BITS +: SIZE_BITS];
      req_align_q <= s_axis_tdata[ADDR_BITS+SIZE_BITS +: AlignBits];
    end
    if (cmd_i.pend_load) begin
      if (cmd_i.pend_from_req) begin
        pend_addr_q  <= req_addr_q;
        pend_bytes_q <= req_bytes_q;
        pend_align_q <= req_align_q;
      end else begin
        pend_addr_q  <= e_addr_q[0];
        pend_bytes_q <= e_bytes_q[0];
        pend_align_q <= e_align_q[0];
      end
    end
    if (cmd_i.push) begin
      o_addr_q  <= o_addr_d;
      o_bytes_q <= o_bytes_d;
      o_align_q <= o_align_d;
      act_q     <= cmd_i.act;
      last_q    <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      tot_q       <= '0;
      idx_q       <= '0;
      req_op_q    <= OP_NONE;
      ov_q        <= 1'b0;
      max_cnt_q   <= CfgCountBits'(16);
      max_bytes_q <= '1;
    end else begin
      cnt_q <= cnt_d;
      tot_q <= tot_d;
      if (cmd_i.latch) begin
        req_op_q <= in_op_i;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.push) begin
        ov_q <= 1'b1;
      end else if (m_axis_tready) begin
        ov_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MAX_COUNT: max_cnt_q   <= cfg_data_i[CfgCountBits-1:0];
          CFG_MAX_BYTES: max_bytes_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = last_q;
  assign m_axis_tuser  = act_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, o_align_q, o_bytes_q, o_addr_q};

  `FBC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "entry count beyond depth")
  `FBC_ASSERT_IMP(a_rm_nonempty, cmd_i.remove, cnt_q != '0, "removal from empty store")
  `FBC_ASSERT_IMP(a_push_free, cmd_i.push, !ov_q || m_axis_tready, "result overwritten")
  `FBC_ASSERT_NXT(a_app_grows, cmd_i.append && !cmd_i.remove && room, cnt_q != $past(cnt_q), "append lost")

endmodule

FILE: src/free_block_cache_fifo_evict_unit.sv
// Free block cache with oldest-first eviction: top level.
// Requests are taken one at a time; s_axis_tready is high only while the unit
// is idle. An allocate compares the cached entries one at a time, as a single
// comparator walks the entries from oldest to newest until it finds an exact
// size and alignment match. A free evicts blocks oldest first, the incoming
// block included when it is freed itself; an oversized or null free evicts
// nothing. A flush releases every cached block. Each result waits in an output
// register and stalls the sequence while m_axis_tready is low. Configuration
// writes are always accepted and should be made only while the unit is idle.
module free_block_cache_fifo_evict_unit #(
  parameter int unsigned DEPTH     = fbc_pkg::DepthDefault,
  parameter int unsigned ADDR_BITS = fbc_pkg::AddrBitsDefault,
  parameter int unsigned SIZE_BITS = fbc_pkg::SizeBitsDefault,
  parameter int unsigned DATA_W    =
    ((ADDR_BITS + SIZE_BITS + fbc_pkg::AlignBits + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // block_addr, block_bytes, block_align, zero pad
  input  logic [DATA_W-1:0]                 s_axis_tdata,
  // op
  input  logic [fbc_pkg::CodeBits-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_addr, out_bytes, out_align, zero pad
  output logic [DATA_W-1:0]                 m_axis_tdata,
  // action
  output logic [fbc_pkg::CodeBits-1:0]      m_axis_tuser,
  output logic                              m_axis_tlast,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fbc_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [fbc_pkg::CfgBytesBits-1:0]  cfg_data_i
);
  import fbc_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  op_e   in_op;

  assign in_op       = op_e'(s_axis_tuser);
  assign cfg_ready_o = 1'b1;

  fbc_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .in_op_i       (in_op),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  fbc_datapath #(
    .DEPTH     (DEPTH),
    .ADDR_BITS (ADDR_BITS),
    .SIZE_BITS (SIZE_BITS),
    .DATA_W    (DATA_W)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .in_op_i       (in_op),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
